[rtl/cfwr_pkg.sv]
// Shared types and constants for the circular FIFO with remove.
package cfwr_pkg;

  // Default sizing
  localparam int unsigned DEPTH_C    = 16;
  localparam int unsigned ID_WIDTH_C = 16;

  // Port field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CUST_W   = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned FREE_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_PEEK   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RDWAIT,
    ST_SRCH,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    push_wr;
    logic    pop_upd;
    logic    rd_head;
    logic    srch_init;
    logic    srch_step;
    logic    shift_init;
    logic    shift_step;
    logic    rm_done;
    logic    set_res;
    status_e res_status;
    logic    res_take_rd;
    logic    load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  empty;
    logic  match;
    logic  rd_more;
    logic  pend;
  } sts_t;

endpackage

[rtl/circular_fifo_with_remove_top.sv]
// Top level of the circular FIFO of identifiers with remove-by-value.
// A ring-buffer queue of DEPTH identifiers, ID_WIDTH bits each, held in a
// single-port-read, single-port-write memory. Each item carries a mode:
// push, pop, peek, or remove the first entry equal to customer_id (later
// entries move one slot toward the head). Every item yields one result with
// status, the popped or peeked value and the free slot count. Remove is
// bound by the memory's single read port: the live entries are scanned one
// per cycle and then each later entry moves one per cycle. One item is in
// work at a time; the next is accepted as soon as the previous result sits
// in the output register.
module circular_fifo_with_remove_top import cfwr_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_C,
  parameter int unsigned ID_WIDTH = ID_WIDTH_C
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [CUST_W-1:0]   customer_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [VALUE_W-1:0]  value_out_o,
  output logic [FREE_W-1:0]   free_slots_o
);

  cmd_t cmd;
  sts_t sts;

  cfwr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfwr_datapath #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_i),
    .customer_id_i (customer_id_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .free_slots_o  (free_slots_o)
  );

endmodule

[rtl/cfwr_datapath.sv]
// Datapath: slot memory, head/count registers, scan counters and result registers.
module cfwr_datapath import cfwr_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_C,
  parameter int unsigned ID_WIDTH = ID_WIDTH_C
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [CUST_W-1:0]   customer_id_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [VALUE_W-1:0]  value_out_o,
  output logic [FREE_W-1:0]   free_slots_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // Slot memory
  logic [ID_WIDTH-1:0] mem_q [DEPTH];
  logic [ID_WIDTH-1:0] rdata_q;

  // Captured item
  mode_e               mode_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [31:0]         id_ext;

  // Queue control state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rk_q, rk_d;
  logic [CW-1:0] wk_q, wk_d;
  logic          pend_q, pend_d;

  // Result staging and output registers
  status_e              st_status_q;
  logic [VALUE_W-1:0]   st_value_q;
  logic [STATUS_W-1:0]  status_q;
  logic [VALUE_W-1:0]   value_q;
  logic [FREE_W-1:0]    free_q;
  logic [31:0]          rd_ext;
  logic [31:0]          free_ext;

  // Memory port control
  logic                we, re, rd_more;
  logic [AW-1:0]       waddr, raddr;
  logic [ID_WIDTH-1:0] wdata;

  // Physical slot of a logical offset from the head
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign id_ext   = 32'(customer_id_i);
  assign rd_ext   = 32'(rdata_q);
  assign free_ext = 32'(DEPTH) - 32'(count_q);
  assign rd_more  = (rk_q < count_q);

  // Memory address and enable selection
  assign we    = cmd_i.push_wr | (cmd_i.shift_step & pend_q);
  assign waddr = cmd_i.push_wr ? slot_at(head_q, count_q) : slot_at(head_q, wk_q);
  assign wdata = cmd_i.push_wr ? id_q : rdata_q;
  assign re    = cmd_i.rd_head | cmd_i.srch_step | (cmd_i.shift_step & rd_more);
  assign raddr = cmd_i.rd_head ? head_q : slot_at(head_q, rk_q);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // Next-state logic for head, count and scan pointers
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rk_d    = rk_q;
    wk_d    = wk_q;
    pend_d  = pend_q;
    if (cmd_i.push_wr) count_d = count_q + CW'(1);
    if (cmd_i.pop_upd) begin
      count_d = count_q - CW'(1);
      if (count_q == CW'(1)) head_d = '0;
      else if (head_q == AW'(DEPTH - 1)) head_d = '0;
      else head_d = head_q + AW'(1);
    end
    if (cmd_i.rm_done) begin
      count_d = count_q - CW'(1);
      if (count_q == CW'(1)) head_d = '0;
    end
    if (cmd_i.srch_init) begin
      rk_d   = '0;
      pend_d = 1'b0;
    end
    if (cmd_i.srch_step) begin
      rk_d   = rk_q + CW'(1);
      pend_d = 1'b1;
    end
    // match sits at rk-1; shifting starts there, next read stays at rk
    if (cmd_i.shift_init) begin
      wk_d   = rk_q - CW'(1);
      pend_d = 1'b0;
    end
    if (cmd_i.shift_step) begin
      if (pend_q) wk_d = wk_q + CW'(1);
      if (rd_more) begin
        rk_d   = rk_q + CW'(1);
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rk_q    <= '0;
      wk_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rk_q    <= rk_d;
      wk_q    <= wk_d;
      pend_q  <= pend_d;
    end
  end

  // Item capture, result staging and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_e'(mode_i);
      id_q   <= id_ext[ID_WIDTH-1:0];
    end
    if (cmd_i.set_res) begin
      st_status_q <= cmd_i.res_status;
      st_value_q  <= cmd_i.res_take_rd ? rd_ext[VALUE_W-1:0] : '0;
    end
    if (cmd_i.load_out) begin
      status_q <= st_status_q;
      value_q  <= st_value_q;
      free_q   <= free_ext[FREE_W-1:0];
    end
  end

  // Status to controller
  always_comb begin
    sts_o.mode    = mode_q;
    sts_o.full    = (count_q == CW'(DEPTH));
    sts_o.empty   = (count_q == '0);
    sts_o.match   = pend_q && (rdata_q == id_q);
    sts_o.rd_more = rd_more;
    sts_o.pend    = pend_q;
  end

  assign status_o     = status_q;
  assign value_out_o  = value_q;
  assign free_slots_o = free_q;

endmodule

[rtl/cfwr_ctrl.sv]
// Controller: state machine sequencing each operation and the handshakes.
module cfwr_ctrl import cfwr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.mode == MODE_PUSH) begin
          cmd_o.set_res = 1'b1;
          if (sts_i.full) begin
            cmd_o.res_status = STAT_FULL;
          end else begin
            cmd_o.push_wr    = 1'b1;
            cmd_o.res_status = STAT_OK;
          end
          state_d = ST_FINISH;
        end else if (sts_i.empty) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = STAT_EMPTY;
          state_d          = ST_FINISH;
        end else if (sts_i.mode == MODE_REMOVE) begin
          cmd_o.srch_init = 1'b1;
          state_d         = ST_SRCH;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = ST_RDWAIT;
        end
      end
      // head entry is in the read register
      ST_RDWAIT: begin
        cmd_o.set_res     = 1'b1;
        cmd_o.res_status  = STAT_OK;
        cmd_o.res_take_rd = 1'b1;
        cmd_o.pop_upd     = (sts_i.mode == MODE_POP);
        state_d           = ST_FINISH;
      end
      // one entry read per cycle, compared once it sits in the read register
      ST_SRCH: begin
        if (sts_i.match) begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT;
        end else if (sts_i.rd_more) begin
          cmd_o.srch_step = 1'b1;
        end else begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = STAT_NOTFOUND;
          state_d          = ST_FINISH;
        end
      end
      // move later entries one slot toward the head
      ST_SHIFT: begin
        if (sts_i.pend || sts_i.rd_more) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          cmd_o.rm_done    = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = STAT_OK;
          state_d          = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid holds until taken
  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_out;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
